// File: rtl/core/bbi2c_pkg.sv
package bbi2c_pkg;

  // Request kinds carried on the input sideband
  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_START = 2'd1,
    REQ_LOAD  = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  // Transfer modes
  typedef enum logic [1:0] {
    MODE_WRITE = 2'd0,
    MODE_READ  = 2'd1,
    MODE_MEMRD = 2'd2,
    MODE_MEMWR = 2'd3
  } mode_t;

  // Bus phases
  typedef enum logic [2:0] {
    PH_START = 3'd0,
    PH_DEV   = 3'd1,
    PH_MEM   = 3'd2,
    PH_RD    = 3'd3,
    PH_WR    = 3'd4,
    PH_STOP  = 3'd5
  } phase_t;

  localparam logic [3:0] RW_BIT   = 4'd7;
  localparam logic [3:0] ACK_BIT  = 4'd8;
  localparam logic       READ_DIR = 1'b1;

  // One result item
  typedef struct packed {
    logic       rejected;
    logic [7:0] rx_byte;
    logic       rx_valid;
    logic       nack_error;
    logic       done_res;
    logic       busy_res;
    logic       sda_out;
    logic       scl_out;
  } result_t;

  // Serial bit of a byte, MSB first; released past the last data bit
  function automatic logic bit_of(input logic [7:0] b, input logic [3:0] cnt);
    logic r;
    if (cnt[3]) begin
      r = 1'b1;
    end else begin
      r = b[~cnt[2:0]];
    end
    return r;
  endfunction

endpackage

// File: rtl/core/bbi2c_store.sv
module bbi2c_store #(
  parameter int BUF_DEPTH = 256,
  parameter int IW        = 8
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [7:0]    load_index,
  input  logic [7:0]    load_value,
  input  logic [IW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  typedef logic [IW-1:0] idx_map_t [256];

  // Load index wrapped to the store depth, built at elaboration
  function automatic idx_map_t load_map_init();
    idx_map_t m;
    for (int i = 0; i < 256; i++) begin
      m[i] = IW'(i % BUF_DEPTH);
    end
    return m;
  endfunction

  localparam idx_map_t LOAD_MAP = load_map_init();

  logic [7:0]    mem [BUF_DEPTH];
  logic [IW-1:0] wr_addr;

  assign wr_addr = LOAD_MAP[load_index];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= load_value;
    end
  end

  // Registered read, same-edge write forwarded
  always_ff @(posedge clk) begin
    if (wr_en && (wr_addr == rd_addr)) begin
      rd_data <= load_value;
    end else begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/core/bbi2c_ctrl.sv
module bbi2c_ctrl #(
  parameter int BUF_DEPTH = 256,
  parameter int IW        = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              acc,
  input  logic [1:0]        req_type,
  input  logic              sda_in,
  input  logic [1:0]        xfer_mode,
  input  logic [7:0]        device_byte,
  input  logic [15:0]       memory_address,
  input  logic [8:0]        transfer_length,
  input  logic [7:0]        rd_data,
  output logic [IW-1:0]     rd_addr,
  output bbi2c_pkg::result_t res
);

  localparam logic [3:0] RXV_CNT = 4'd7;

  bbi2c_pkg::phase_t phase, phase_next;
  logic [1:0]  mode_reg, mode_reg_next;
  logic        mem_stage, mem_stage_next;
  logic        rw_flag, rw_flag_next;
  logic [3:0]  bit_count, bit_count_next;
  logic [8:0]  byte_pos, byte_pos_next;
  logic [IW-1:0] idx, idx_next;
  logic        nack_seen, nack_seen_next;
  logic        scl_level, scl_level_next;
  logic        sda_level, sda_level_next;
  logic        start_nack_handled, start_nack_handled_next;
  logic        stop_after_ack, stop_after_ack_next;
  logic [7:0]  device_reg, device_reg_next;
  logic [15:0] memaddr_reg, memaddr_reg_next;
  logic [8:0]  length_reg, length_reg_next;
  logic [7:0]  rx_shift, rx_shift_next;
  logic        busy_flag, busy_flag_next;

  logic        done_c, rxv_c, rej_c;
  logic [IW-1:0] idx_inc;
  logic [8:0]  bp_inc;

  assign idx_inc = (idx == IW'(BUF_DEPTH - 1)) ? '0 : idx + 1'b1;
  assign bp_inc  = byte_pos + 9'd1;

  // Next state: one tick of the phase machine, or a start
  always_comb begin
    logic adv;
    logic [7:0] mb;
    phase_next              = phase;
    mode_reg_next           = mode_reg;
    mem_stage_next          = mem_stage;
    rw_flag_next            = rw_flag;
    bit_count_next          = bit_count;
    byte_pos_next           = byte_pos;
    idx_next                = idx;
    nack_seen_next          = nack_seen;
    scl_level_next          = scl_level;
    sda_level_next          = sda_level;
    start_nack_handled_next = start_nack_handled;
    stop_after_ack_next     = stop_after_ack;
    device_reg_next         = device_reg;
    memaddr_reg_next        = memaddr_reg;
    length_reg_next         = length_reg;
    rx_shift_next           = rx_shift;
    busy_flag_next          = busy_flag;
    adv                     = 1'b0;
    mb                      = (byte_pos != 9'd0) ? memaddr_reg[7:0] : memaddr_reg[15:8];

    unique case (bbi2c_pkg::req_t'(req_type))
      bbi2c_pkg::REQ_START: begin
        if (!busy_flag && (transfer_length != 9'd0)) begin
          mode_reg_next    = xfer_mode;
          device_reg_next  = device_byte;
          memaddr_reg_next = memory_address;
          length_reg_next  = transfer_length;
          byte_pos_next    = '0;
          idx_next         = '0;
          bit_count_next   = '0;
          nack_seen_next   = 1'b0;
          mem_stage_next   = 1'b0;
          rw_flag_next     = (xfer_mode == bbi2c_pkg::MODE_READ) ? bbi2c_pkg::READ_DIR
                                                                 : 1'b0;
          phase_next       = bbi2c_pkg::PH_START;
          busy_flag_next   = 1'b1;
        end
      end
      bbi2c_pkg::REQ_TICK: begin
        if (busy_flag) begin
          unique case (phase)
            bbi2c_pkg::PH_START: begin
              if (!scl_level) begin
                scl_level_next = 1'b1;
              end else if (!sda_in) begin
                scl_level_next = 1'b0;
                sda_level_next = 1'b1;
              end else if (nack_seen && !start_nack_handled) begin
                scl_level_next          = 1'b0;
                start_nack_handled_next = 1'b1;
              end else begin
                sda_level_next          = 1'b0;
                start_nack_handled_next = 1'b0;
                adv                     = 1'b1;
              end
            end
            bbi2c_pkg::PH_DEV: begin
              scl_level_next = ~scl_level;
              if (scl_level) begin
                if (bit_count == bbi2c_pkg::RW_BIT) begin
                  sda_level_next = rw_flag;
                end else if (bit_count == bbi2c_pkg::ACK_BIT) begin
                  sda_level_next = 1'b1;
                end else begin
                  sda_level_next = bbi2c_pkg::bit_of(device_reg, bit_count);
                end
              end else if (bit_count == bbi2c_pkg::ACK_BIT) begin
                nack_seen_next = sda_in;
                adv            = 1'b1;
              end else begin
                bit_count_next = bit_count + 4'd1;
              end
            end
            bbi2c_pkg::PH_MEM: begin
              scl_level_next = ~scl_level;
              if (scl_level) begin
                sda_level_next = (bit_count == bbi2c_pkg::ACK_BIT) ? 1'b1
                               : bbi2c_pkg::bit_of(mb, bit_count);
              end else if (bit_count == bbi2c_pkg::ACK_BIT) begin
                nack_seen_next = sda_in;
                if (sda_in || (byte_pos != 9'd0)) begin
                  adv = 1'b1;
                end else begin
                  bit_count_next = '0;
                  byte_pos_next  = 9'd1;
                  idx_next       = idx_inc;
                end
              end else begin
                bit_count_next = bit_count + 4'd1;
              end
            end
            bbi2c_pkg::PH_WR: begin
              scl_level_next = ~scl_level;
              if (scl_level) begin
                sda_level_next = (bit_count == bbi2c_pkg::ACK_BIT) ? 1'b1
                               : bbi2c_pkg::bit_of(rd_data, bit_count);
              end else if (bit_count == bbi2c_pkg::ACK_BIT) begin
                nack_seen_next = sda_in;
                if (sda_in || (byte_pos == length_reg - 9'd1)) begin
                  adv = 1'b1;
                end else begin
                  bit_count_next = '0;
                  byte_pos_next  = bp_inc;
                  idx_next       = idx_inc;
                end
              end else begin
                bit_count_next = bit_count + 4'd1;
              end
            end
            bbi2c_pkg::PH_RD: begin
              scl_level_next = ~scl_level;
              if (scl_level) begin
                if (bit_count == bbi2c_pkg::ACK_BIT) begin
                  byte_pos_next  = bp_inc;
                  idx_next       = idx_inc;
                  sda_level_next = (bp_inc == length_reg);
                end else begin
                  sda_level_next = 1'b1;
                end
              end else if (bit_count != bbi2c_pkg::ACK_BIT) begin
                rx_shift_next  = {rx_shift[6:0], sda_in};
                bit_count_next = bit_count + 4'd1;
              end else begin
                bit_count_next = '0;
                if (byte_pos == length_reg) begin
                  adv = 1'b1;
                end
              end
            end
            default: begin
              // STOP sequence
              if (!scl_level) begin
                scl_level_next = 1'b1;
              end else if (!sda_in) begin
                if (stop_after_ack) begin
                  scl_level_next      = 1'b0;
                  sda_level_next      = 1'b0;
                  stop_after_ack_next = 1'b0;
                end else begin
                  sda_level_next      = 1'b1;
                  stop_after_ack_next = 1'b1;
                  busy_flag_next      = 1'b0;
                end
              end else begin
                scl_level_next = 1'b0;
                sda_level_next = 1'b0;
              end
            end
          endcase
        end
      end
      default: begin
      end
    endcase

    // Phase advance after a START or an ACK slot
    if (adv) begin
      if (nack_seen_next) begin
        phase_next = bbi2c_pkg::PH_STOP;
      end else begin
        case (phase)
          bbi2c_pkg::PH_START: begin
            phase_next     = bbi2c_pkg::PH_DEV;
            bit_count_next = '0;
          end
          bbi2c_pkg::PH_DEV: begin
            bit_count_next = '0;
            byte_pos_next  = '0;
            idx_next       = '0;
            case (bbi2c_pkg::mode_t'(mode_reg))
              bbi2c_pkg::MODE_READ:  phase_next = bbi2c_pkg::PH_RD;
              bbi2c_pkg::MODE_WRITE: phase_next = bbi2c_pkg::PH_WR;
              bbi2c_pkg::MODE_MEMRD: phase_next = mem_stage ? bbi2c_pkg::PH_RD
                                                            : bbi2c_pkg::PH_MEM;
              default:               phase_next = bbi2c_pkg::PH_MEM;
            endcase
          end
          bbi2c_pkg::PH_MEM: begin
            bit_count_next = '0;
            byte_pos_next  = '0;
            idx_next       = '0;
            if (mode_reg == bbi2c_pkg::MODE_MEMRD) begin
              rw_flag_next   = bbi2c_pkg::READ_DIR;
              phase_next     = bbi2c_pkg::PH_START;
              mem_stage_next = 1'b1;
            end else if (mode_reg == bbi2c_pkg::MODE_MEMWR) begin
              phase_next = bbi2c_pkg::PH_WR;
            end
          end
          bbi2c_pkg::PH_RD, bbi2c_pkg::PH_WR: begin
            phase_next = bbi2c_pkg::PH_STOP;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Outputs: events of this item and the levels after it
  always_comb begin
    done_c = (req_type == bbi2c_pkg::REQ_TICK) && busy_flag
          && (phase == bbi2c_pkg::PH_STOP) && scl_level && !sda_in && !stop_after_ack;
    rxv_c  = (req_type == bbi2c_pkg::REQ_TICK) && busy_flag
          && (phase == bbi2c_pkg::PH_RD) && !scl_level && (bit_count == RXV_CNT);
    rej_c  = (req_type == bbi2c_pkg::REQ_START) && (busy_flag || (transfer_length == 9'd0));
    res.scl_out    = scl_level_next;
    res.sda_out    = sda_level_next;
    res.busy_res   = busy_flag_next;
    res.done_res   = done_c;
    res.nack_error = done_c && nack_seen;
    res.rx_valid   = rxv_c;
    res.rx_byte    = rxv_c ? {rx_shift[6:0], sda_in} : 8'd0;
    res.rejected   = rej_c;
  end

  // Store prefetch address follows the byte position
  assign rd_addr = acc ? idx_next : idx;

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= bbi2c_pkg::PH_STOP;
      mode_reg           <= '0;
      mem_stage          <= 1'b0;
      rw_flag            <= 1'b0;
      bit_count          <= '0;
      byte_pos           <= '0;
      idx                <= '0;
      nack_seen          <= 1'b0;
      scl_level          <= 1'b1;
      sda_level          <= 1'b1;
      start_nack_handled <= 1'b0;
      stop_after_ack     <= 1'b1;
      device_reg         <= '0;
      memaddr_reg        <= '0;
      length_reg         <= '0;
      rx_shift           <= '0;
      busy_flag          <= 1'b0;
    end else if (acc) begin
      phase              <= phase_next;
      mode_reg           <= mode_reg_next;
      mem_stage          <= mem_stage_next;
      rw_flag            <= rw_flag_next;
      bit_count          <= bit_count_next;
      byte_pos           <= byte_pos_next;
      idx                <= idx_next;
      nack_seen          <= nack_seen_next;
      scl_level          <= scl_level_next;
      sda_level          <= sda_level_next;
      start_nack_handled <= start_nack_handled_next;
      stop_after_ack     <= stop_after_ack_next;
      device_reg         <= device_reg_next;
      memaddr_reg        <= memaddr_reg_next;
      length_reg         <= length_reg_next;
      rx_shift           <= rx_shift_next;
      busy_flag          <= busy_flag_next;
    end
  end

  // Completion leaves the bus idle in STOP
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    (acc && done_c) |=> (!busy_flag && (phase == bbi2c_pkg::PH_STOP)))
    else $error("done without returning to idle");

  // A refused start does not disturb a running transfer
  a_rej_hold: assert property (@(posedge clk) disable iff (rst)
    (!rst && acc && rej_c) |=> (busy_flag == $past(busy_flag)))
    else $error("rejected start changed busy");

  // A received byte lands on the ACK slot
  a_rx_ack: assert property (@(posedge clk) disable iff (rst)
    (!rst && acc && rxv_c) |=> (bit_count == bbi2c_pkg::ACK_BIT))
    else $error("rx byte not followed by ACK slot");

  // An idle master leaves SCL released
  a_idle_scl: assert property (@(posedge clk) disable iff (rst)
    !busy_flag |-> scl_level)
    else $error("SCL held low while idle");

endmodule

// File: rtl/core/bbi2c_outreg.sv
module bbi2c_outreg (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_acc,
  input  bbi2c_pkg::result_t in_res,
  output logic               in_ready,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [15:0]        m_axis_tdata
);

  logic               valid;
  bbi2c_pkg::result_t data;

  assign in_ready      = !valid || m_axis_tready;
  assign m_axis_tvalid = valid;
  assign m_axis_tdata  = {1'b0, data};

  // Output register valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_acc) begin
      valid <= 1'b1;
    end else if (m_axis_tready) begin
      valid <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      data <= in_res;
    end
  end

endmodule

// File: rtl/core/bitbang_i2c_master_top.sv
// Output: a result is registered onto the master port in the cycle after its input transfer.
// Throughput: one item per cycle while the master port is not stalled; each item is one
//   update of the phase registers; the write store is read ahead through its registered port.
// Reset: synchronous, active high; clears the phase machine to idle STOP with SCL/SDA
//   released and empties the output register. Write store contents are undefined until loaded.
module bitbang_i2c_master_top #(
  parameter int BUF_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // sda_in[0], xfer_mode[2:1], device_byte[10:3], memory_address[26:11],
  // transfer_length[35:27], load_index[43:36], load_value[51:44], zero pad
  input  logic [55:0] s_axis_tdata,
  // req_type[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // scl_out[0], sda_out[1], busy_res[2], done_res[3], nack_error[4],
  // rx_valid[5], rx_byte[13:6], rejected[14], zero pad
  output logic [15:0] m_axis_tdata
);

  localparam int IW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;

  logic               acc;
  logic               load_en;
  logic [IW-1:0]      rd_addr;
  logic [7:0]         rd_data;
  bbi2c_pkg::result_t res;

  assign acc     = s_axis_tvalid && s_axis_tready;
  assign load_en = acc && (s_axis_tuser == bbi2c_pkg::REQ_LOAD);

  bbi2c_store #(
    .BUF_DEPTH (BUF_DEPTH),
    .IW        (IW)
  ) u_store (
    .clk        (clk),
    .wr_en      (load_en),
    .load_index (s_axis_tdata[43:36]),
    .load_value (s_axis_tdata[51:44]),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data)
  );

  bbi2c_ctrl #(
    .BUF_DEPTH (BUF_DEPTH),
    .IW        (IW)
  ) u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .acc             (acc),
    .req_type        (s_axis_tuser),
    .sda_in          (s_axis_tdata[0]),
    .xfer_mode       (s_axis_tdata[2:1]),
    .device_byte     (s_axis_tdata[10:3]),
    .memory_address  (s_axis_tdata[26:11]),
    .transfer_length (s_axis_tdata[35:27]),
    .rd_data         (rd_data),
    .rd_addr         (rd_addr),
    .res             (res)
  );

  bbi2c_outreg u_outreg (
    .clk           (clk),
    .rst           (rst),
    .in_acc        (acc),
    .in_res        (res),
    .in_ready      (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

// File: test/bitbang_i2c_master_checker.sv
module bitbang_i2c_master_checker
  import bbi2c_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  // sda_in[0], xfer_mode[2:1], device_byte[10:3], memory_address[26:11],
  // transfer_length[35:27], load_index[43:36], load_value[51:44], zero pad
  input  logic [55:0] s_axis_tdata,
  // req_type[1:0]
  input  logic [1:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // scl_out[0], sda_out[1], busy_res[2], done_res[3], nack_error[4],
  // rx_valid[5], rx_byte[13:6], rejected[14], zero pad
  input  logic [15:0] m_axis_tdata,
  output int          mismatches,
  output int          pending,
  output phase_t      ex_phase,
  output logic [3:0]  ex_bit,
  output logic        ex_busy
);

  // predicted master state
  phase_t      bus_phase;
  mode_t       xfer_md;
  logic        repeat_done;
  logic        rw_bit;
  logic [3:0]  bit_idx;
  logic [8:0]  byte_idx;
  logic        got_nack;
  logic        scl_lvl;
  logic        sda_lvl;
  logic        start_nack_seen;
  logic        stop_ack_armed;
  logic [7:0]  dev_byte;
  logic [15:0] mem_addr;
  logic [8:0]  xfer_len;
  logic [7:0]  rx_sr;
  logic        busy;
  logic [7:0]  wr_store [256];

  // events of the current item
  logic        done_ev, err_ev, rxv_ev, refused;
  logic [7:0]  rxb_ev;

  result_t     status_q [$];
  result_t     got, want;

  initial mismatches = 0;
  initial pending = 0;

  assign ex_phase = bus_phase;
  assign ex_bit   = bit_idx;
  assign ex_busy  = busy;

  // MSB-first serial bit, released past bit 7
  function automatic logic serial_bit(input logic [7:0] b, input logic [3:0] cnt);
    if (cnt >= 4'd8) return 1'b1;
    return b[3'd7 - cnt[2:0]];
  endfunction

  // next phase once a START, or a byte and its ACK slot, are done
  task automatic advance();
    if (got_nack) begin
      bus_phase = PH_STOP;
      return;
    end
    case (bus_phase)
      PH_START: begin
        bus_phase = PH_DEV;
        bit_idx = 4'd0;
      end
      PH_DEV: begin
        bit_idx = 4'd0;
        byte_idx = 9'd0;
        case (xfer_md)
          MODE_READ:  bus_phase = PH_RD;
          MODE_WRITE: bus_phase = PH_WR;
          MODE_MEMRD: bus_phase = repeat_done ? PH_RD : PH_MEM;
          default:    bus_phase = PH_MEM;
        endcase
      end
      PH_MEM: begin
        bit_idx = 4'd0;
        byte_idx = 9'd0;
        if (xfer_md == MODE_MEMRD) begin
          rw_bit = READ_DIR;
          bus_phase = PH_START;
          repeat_done = 1'b1;
        end else if (xfer_md == MODE_MEMWR) begin
          bus_phase = PH_WR;
        end
      end
      PH_RD, PH_WR: bus_phase = PH_STOP;
      default: ;
    endcase
  endtask

  task automatic start_cond(input logic line);
    if (!scl_lvl) begin
      scl_lvl = 1'b1;
    end else if (!line) begin
      scl_lvl = 1'b0;
      sda_lvl = 1'b1;
    end else if (got_nack && !start_nack_seen) begin
      scl_lvl = 1'b0;
      start_nack_seen = 1'b1;
    end else begin
      sda_lvl = 1'b0;
      start_nack_seen = 1'b0;
      advance();
    end
  endtask

  task automatic stop_cond(input logic line);
    if (!scl_lvl) begin
      scl_lvl = 1'b1;
    end else if (!line) begin
      if (stop_ack_armed) begin
        scl_lvl = 1'b0;
        sda_lvl = 1'b0;
        stop_ack_armed = 1'b0;
      end else begin
        sda_lvl = 1'b1;
        stop_ack_armed = 1'b1;
        busy = 1'b0;
        done_ev = 1'b1;
        err_ev = got_nack;
      end
    end else begin
      scl_lvl = 1'b0;
      sda_lvl = 1'b0;
    end
  endtask

  task automatic dev_bit(input logic line);
    if (!scl_lvl) begin
      if (bit_idx == RW_BIT) sda_lvl = rw_bit;
      else if (bit_idx == ACK_BIT) sda_lvl = 1'b1;
      else sda_lvl = serial_bit(dev_byte, bit_idx);
    end else if (bit_idx == ACK_BIT) begin
      got_nack = line;
      advance();
    end else begin
      bit_idx = bit_idx + 4'd1;
    end
  endtask

  // memory address, high byte first
  task automatic mem_bit(input logic line);
    logic [7:0] b;
    if (!scl_lvl) begin
      b = (byte_idx != 9'd0) ? mem_addr[7:0] : mem_addr[15:8];
      sda_lvl = (bit_idx == ACK_BIT) ? 1'b1 : serial_bit(b, bit_idx);
    end else if (bit_idx == ACK_BIT) begin
      got_nack = line;
      if (got_nack || byte_idx != 9'd0) begin
        advance();
      end else begin
        bit_idx = 4'd0;
        byte_idx = 9'd1;
      end
    end else begin
      bit_idx = bit_idx + 4'd1;
    end
  endtask

  task automatic write_bit(input logic line);
    if (!scl_lvl) begin
      sda_lvl = (bit_idx == ACK_BIT) ? 1'b1 : serial_bit(wr_store[byte_idx[7:0]], bit_idx);
    end else if (bit_idx == ACK_BIT) begin
      got_nack = line;
      if (got_nack || byte_idx == xfer_len - 9'd1) begin
        advance();
      end else begin
        bit_idx = 4'd0;
        byte_idx = byte_idx + 9'd1;
      end
    end else begin
      bit_idx = bit_idx + 4'd1;
    end
  endtask

  // master answers ACK, or NACK on the final byte
  task automatic read_bit(input logic line);
    if (!scl_lvl) begin
      if (bit_idx == ACK_BIT) begin
        byte_idx = byte_idx + 9'd1;
        sda_lvl = (byte_idx == xfer_len);
      end else begin
        sda_lvl = 1'b1;
      end
    end else if (bit_idx != ACK_BIT) begin
      rx_sr = {rx_sr[6:0], line};
      bit_idx = bit_idx + 4'd1;
      if (bit_idx == ACK_BIT) begin
        rxv_ev = 1'b1;
        rxb_ev = rx_sr;
      end
    end else begin
      bit_idx = 4'd0;
      if (byte_idx == xfer_len) advance();
    end
  endtask

  task automatic master_step(input req_t kind, input logic [55:0] payload,
                             output result_t res);
    logic line;
    line = payload[0];
    done_ev = 1'b0;
    err_ev = 1'b0;
    rxv_ev = 1'b0;
    rxb_ev = 8'h00;
    refused = 1'b0;
    case (kind)
      REQ_START: begin
        if (busy || payload[35:27] == 9'd0) begin
          refused = 1'b1;
        end else begin
          xfer_md = mode_t'(payload[2:1]);
          dev_byte = payload[10:3];
          mem_addr = payload[26:11];
          xfer_len = payload[35:27];
          byte_idx = 9'd0;
          bit_idx = 4'd0;
          got_nack = 1'b0;
          repeat_done = 1'b0;
          rw_bit = (xfer_md == MODE_READ) ? READ_DIR : ~READ_DIR;
          bus_phase = PH_START;
          busy = 1'b1;
        end
      end
      REQ_LOAD: wr_store[payload[43:36]] = payload[51:44];
      REQ_TICK: begin
        if (busy) begin
          if (bus_phase != PH_START && bus_phase != PH_STOP) scl_lvl = ~scl_lvl;
          case (bus_phase)
            PH_START: start_cond(line);
            PH_DEV:   dev_bit(line);
            PH_MEM:   mem_bit(line);
            PH_RD:    read_bit(line);
            PH_WR:    write_bit(line);
            default:  stop_cond(line);
          endcase
        end
      end
      default: ;
    endcase
    res.scl_out    = scl_lvl;
    res.sda_out    = sda_lvl;
    res.busy_res   = busy;
    res.done_res   = done_ev;
    res.nack_error = err_ev;
    res.rx_valid   = rxv_ev;
    res.rx_byte    = rxb_ev;
    res.rejected   = refused;
  endtask

  // compare outgoing transfers, then predict incoming ones
  always @(posedge clk) begin
    if (rst) begin
      bus_phase = PH_STOP;
      xfer_md = MODE_WRITE;
      repeat_done = 1'b0;
      rw_bit = 1'b0;
      bit_idx = 4'd0;
      byte_idx = 9'd0;
      got_nack = 1'b0;
      scl_lvl = 1'b1;
      sda_lvl = 1'b1;
      start_nack_seen = 1'b0;
      stop_ack_armed = 1'b1;
      dev_byte = 8'h00;
      mem_addr = 16'h0000;
      xfer_len = 9'd0;
      rx_sr = 8'h00;
      busy = 1'b0;
      status_q.delete();
      pending = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = result_t'(m_axis_tdata[14:0]);
        if (status_q.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result transfer: %h", m_axis_tdata);
          mismatches++;
        end else begin
          want = status_q.pop_front();
          if (got !== want || m_axis_tdata[15] !== 1'b0) begin
            if (mismatches < 10)
              $display({"mismatch: exp scl=%b sda=%b busy=%b done=%b nack=%b rxv=%b ",
                        "rxb=%h rej=%b | got scl=%b sda=%b busy=%b done=%b nack=%b ",
                        "rxv=%b rxb=%h rej=%b pad=%b"},
                       want.scl_out, want.sda_out, want.busy_res, want.done_res,
                       want.nack_error, want.rx_valid, want.rx_byte, want.rejected,
                       got.scl_out, got.sda_out, got.busy_res, got.done_res,
                       got.nack_error, got.rx_valid, got.rx_byte, got.rejected,
                       m_axis_tdata[15]);
            mismatches++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        master_step(req_t'(s_axis_tuser), s_axis_tdata, want);
        status_q.push_back(want);
      end
      pending = status_q.size();
    end
  end

endmodule

// File: test/bitbang_i2c_master_top_test.sv
module bitbang_i2c_master_top_test;
  import bbi2c_pkg::*;

  localparam int RAND_ITEMS = 550;
  localparam int STALL_LIMIT = 3000;
  localparam int HOLD_AT = 300;
  localparam int HOLD_CYCLES = 400;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = REQ_NONE;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;

  int          mismatches, pending;
  phase_t      ex_phase;
  logic [3:0]  ex_bit;
  logic        ex_busy;

  int          items_sent = 0;
  int          rand_base;
  int          rx_count = 0;
  int          stall_cycles = 0;
  bit          tx_burst = 1'b0;
  bit          rx_burst = 1'b0;
  bit          written [256];

  always #10 clk = ~clk;

  bitbang_i2c_master_top #(.BUF_DEPTH(256)) dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  bitbang_i2c_master_checker chk (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .mismatches(mismatches),
    .pending(pending),
    .ex_phase(ex_phase),
    .ex_bit(ex_bit),
    .ex_busy(ex_busy)
  );

  function automatic bit chance(input int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  function automatic logic [55:0] pack_item(input logic line, input mode_t md,
                                            input logic [7:0] devb, input logic [15:0] addr,
                                            input logic [8:0] len, input logic [7:0] idx,
                                            input logic [7:0] val);
    return {4'b0000, val, idx, len, addr, devb, md, line};
  endfunction

  function automatic logic [55:0] random_item(input logic [8:0] len);
    return pack_item(1'($urandom), mode_t'($urandom_range(0, 3)), 8'($urandom),
                     16'($urandom), len, 8'($urandom), 8'($urandom));
  endfunction

  // one input transfer, after a random gap
  task automatic offer(input req_t kind, input logic [55:0] payload);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tuser  <= kind;
    s_axis_tdata  <= payload;
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
    items_sent++;
    if ($urandom_range(0, 49) == 0) tx_burst = !tx_burst;
  endtask

  // slave side of the bus: mostly cooperative line levels
  task automatic tick(input int nack_pct);
    logic line;
    case (ex_phase)
      PH_START: line = chance(90);
      PH_STOP:  line = !chance(85);
      PH_RD:    line = 1'($urandom);
      default:  line = (ex_bit == ACK_BIT) ? chance(nack_pct) : 1'($urandom);
    endcase
    offer(REQ_TICK, {random_item(9'($urandom))} & ~56'h1 | {55'h0, line});
  endtask

  task automatic load_byte(input logic [7:0] idx, input logic [7:0] val);
    offer(REQ_LOAD, pack_item(1'($urandom), mode_t'($urandom_range(0, 3)), 8'($urandom),
                              16'($urandom), 9'($urandom), idx, val));
    written[idx] = 1'b1;
  endtask

  // loads, refused starts, unused codes and plain ticks
  task automatic noise_item();
    case ($urandom_range(0, 3))
      0: load_byte(8'($urandom), 8'($urandom));
      1: offer(REQ_START, random_item(ex_busy ? 9'($urandom) : 9'd0));
      2: offer(REQ_NONE, random_item(9'($urandom)));
      default: tick(5);
    endcase
  endtask

  task automatic run_transfer(input mode_t md, input logic [7:0] devb,
                              input logic [15:0] addr, input logic [8:0] len,
                              input int nack_pct);
    int i;
    // every store entry a write may send is loaded first
    if (md == MODE_WRITE || md == MODE_MEMWR) begin
      for (i = 0; i < ((len > 9'd256) ? 256 : int'(len)); i++)
        if (!written[i]) load_byte(8'(i), 8'($urandom));
    end
    offer(REQ_START, pack_item(1'($urandom), md, devb, addr, len, 8'($urandom),
                               8'($urandom)));
    while (ex_busy) begin
      if (chance(6)) noise_item();
      else tick(nack_pct);
    end
  endtask

  // result side, with one long hold-off
  initial begin
    int gap;
    while (rst) @(negedge clk);
    m_axis_tready <= 1'b1;
    forever begin
      @(posedge clk);
      if (m_axis_tvalid && m_axis_tready) begin
        rx_count++;
        @(negedge clk);
        if (rx_count == HOLD_AT) gap = HOLD_CYCLES;
        else gap = rx_burst ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
          m_axis_tready <= 1'b0;
          repeat (gap) @(negedge clk);
          m_axis_tready <= 1'b1;
        end
        if ($urandom_range(0, 49) == 0) rx_burst = !rx_burst;
      end
    end
  end

  // watchdog on cycles without any transfer
  initial begin
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    mode_t      md;
    logic [8:0] len;
    int         pick;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // idle items, unused code, zero length, store extremes
    offer(REQ_TICK, pack_item(1'b1, MODE_WRITE, 8'h00, 16'h0000, 9'd0, 8'h00, 8'h00));
    offer(REQ_TICK, pack_item(1'b0, MODE_MEMWR, 8'hFF, 16'hFFFF, 9'h1FF, 8'hFF, 8'hFF));
    offer(REQ_NONE, pack_item(1'b1, MODE_MEMWR, 8'hFF, 16'hFFFF, 9'h1FF, 8'hFF, 8'hFF));
    offer(REQ_START, pack_item(1'b1, MODE_READ, 8'hA0, 16'h0000, 9'd0, 8'h00, 8'h00));
    load_byte(8'h00, 8'h00);
    load_byte(8'hFF, 8'hFF);
    load_byte(8'h01, 8'hA5);

    // each mode once, then a device NACK on a maximal length
    run_transfer(MODE_WRITE, 8'hFF, 16'h0000, 9'd2, 0);
    run_transfer(MODE_READ, 8'h00, 16'hFFFF, 9'd1, 0);
    run_transfer(MODE_MEMRD, 8'hA1, 16'hFFFF, 9'd2, 0);
    run_transfer(MODE_MEMWR, 8'hA0, 16'h0000, 9'd1, 0);
    run_transfer(MODE_READ, 8'h50, 16'h1234, 9'h1FF, 100);

    // random transfers, mostly short and well formed; long ones end on a NACK
    rand_base = items_sent;
    while (items_sent - rand_base < RAND_ITEMS) begin
      repeat ($urandom_range(0, 3)) noise_item();
      md = mode_t'($urandom_range(0, 3));
      pick = $urandom_range(0, 99);
      if (pick < 70) len = 9'($urandom_range(1, 3));
      else if (pick < 95) len = 9'($urandom_range(4, 12));
      else len = 9'($urandom_range(256, 511));
      run_transfer(md, 8'($urandom), 16'($urandom), len, (pick < 95) ? 5 : 100);
    end

    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
